// ----- design/grid_graph_edge_generator_core_assert.svh -----
// Assertion macros shared by the grid graph edge generator checker.
`ifndef GRID_GRAPH_EDGE_GENERATOR_CORE_ASSERT_SVH
`define GRID_GRAPH_EDGE_GENERATOR_CORE_ASSERT_SVH

// Same-cycle implication, checked at every rising edge outside reset.
`define GGEG_ASSERT_IMP(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("ggeg assertion failed");

// Next-cycle implication, checked at every rising edge outside reset.
`define GGEG_ASSERT_NXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("ggeg assertion failed");

`endif

// ----- design/ggeg_pkg.sv -----
// Shared types and constants of the grid graph edge generator.
package ggeg_pkg;

   localparam int GRID_DIM_W   = 13;
   localparam int PIXEL_W      = 12;
   localparam int NODE_W       = 25;
   localparam int KIND_SLOTS   = 4;
   localparam int COUNT_W      = 3;
   localparam int CSR_ADDR_W   = 4;
   localparam int CSR_DATA_W   = 32;
   localparam int DEF_MAX_WIDTH  = 4096;
   localparam int DEF_MAX_HEIGHT = 4096;

   localparam logic [1:0] ANG_VERT = 2'd0;
   localparam logic [1:0] ANG_DIAG = 2'd1;
   localparam logic [1:0] ANG_HORZ = 2'd2;

   // Kind of one forward edge of a pixel.
   typedef enum logic [1:0] {
      EK_RIGHT      = 2'd0,
      EK_DOWN       = 2'd1,
      EK_DOWN_RIGHT = 2'd2,
      EK_DOWN_LEFT  = 2'd3
   } edge_kind_type;

   // Configuration register indexes.
   typedef enum logic [1:0] {
      REG_GRID_WIDTH      = 2'd0,
      REG_GRID_HEIGHT     = 2'd1,
      REG_EIGHT_CONNECTED = 2'd2,
      REG_DIRECTED        = 2'd3
   } csr_index_type;

   // One pixel's work handed to the edge expander.
   typedef struct packed {
      logic [NODE_W-1:0]                   node;       // start node v
      logic [NODE_W-1:0]                   node_down;  // v + width
      edge_kind_type [KIND_SLOTS-1:0]      kinds;      // edge kinds in output order
      logic [COUNT_W-1:0]                  count;      // number of forward edges, 1 to 4
   } edge_item_type;

endpackage

// ----- design/ggeg_expander.sv -----
// Edge expander: a pixel's edge list gives one result per cycle unless stalled.
module ggeg_expander
   import ggeg_pkg::*;
(
   input  logic                clock,
   input  logic                reset,
   input  logic                directed,
   input  logic                item_valid,
   input  edge_item_type       item,
   output logic                item_ready,
   output logic                rsp_valid,
   input  logic                rsp_stall,
   output logic [NODE_W-1:0]   rsp_from_node,
   output logic [NODE_W-1:0]   rsp_to_node,
   output logic                rsp_is_diagonal,
   output logic [1:0]          rsp_angle_code,
   output logic                rsp_last_edge
);

   logic                busy_ff;
   edge_item_type       item_ff;
   logic [1:0]          idx_ff;
   logic                rev_ff;
   logic                rsp_valid_ff;
   logic [NODE_W-1:0]   from_ff;
   logic [NODE_W-1:0]   to_ff;
   logic                diag_ff;
   logic [1:0]          angle_ff;
   logic                last_ff;

   logic                out_free;
   logic                emit;
   logic                last_in;
   logic                load;
   edge_kind_type       kind;
   logic [NODE_W-1:0]   target;
   logic                diag_in;
   logic [1:0]          angle_in;

   // The output register is free when empty or when its transfer completes.
   assign out_free   = !rsp_valid_ff || !rsp_stall;
   assign emit       = busy_ff && out_free;
   assign last_in    = ({1'b0, idx_ff} == (item_ff.count - COUNT_W'(1))) &&
                       (rev_ff || !directed);
   assign item_ready = !busy_ff || (emit && last_in);
   assign load       = item_valid && item_ready;

   // Select the current edge and its far node.
   always_comb begin
      kind     = item_ff.kinds[idx_ff];
      target   = item_ff.node_down;
      diag_in  = 1'b0;
      angle_in = ANG_VERT;
      case (kind)
         EK_RIGHT: begin
            target   = item_ff.node + NODE_W'(1);
            angle_in = ANG_HORZ;
         end
         EK_DOWN: begin
            target   = item_ff.node_down;
            angle_in = ANG_VERT;
         end
         EK_DOWN_RIGHT: begin
            target   = item_ff.node_down + NODE_W'(1);
            diag_in  = 1'b1;
            angle_in = ANG_DIAG;
         end
         EK_DOWN_LEFT: begin
            target   = item_ff.node_down - NODE_W'(1);
            diag_in  = 1'b1;
            angle_in = ANG_DIAG;
         end
         default: begin
            target   = item_ff.node_down;
            angle_in = ANG_VERT;
         end
      endcase
   end

   // Walk the edge list, inserting the reverse edge when the graph is directed.
   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
      end else if (load) begin
         busy_ff <= 1'b1;
      end else if (emit && last_in) begin
         busy_ff <= 1'b0;
      end
      if (load) begin
         item_ff <= item;
         idx_ff  <= 2'd0;
         rev_ff  <= 1'b0;
      end else if (emit) begin
         if (directed && !rev_ff) begin
            rev_ff <= 1'b1;
         end else begin
            rev_ff <= 1'b0;
            idx_ff <= idx_ff + 2'd1;
         end
      end
   end

   // Output register.
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (out_free) begin
         rsp_valid_ff <= emit;
      end
      if (emit) begin
         from_ff  <= rev_ff ? target : item_ff.node;
         to_ff    <= rev_ff ? item_ff.node : target;
         diag_ff  <= diag_in;
         angle_ff <= angle_in;
         last_ff  <= last_in;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_from_node   = from_ff;
   assign rsp_to_node     = to_ff;
   assign rsp_is_diagonal = diag_ff;
   assign rsp_angle_code  = angle_ff;
   assign rsp_last_edge   = last_ff;

endmodule

// ----- design/grid_graph_edge_generator_core.sv -----
// Grid graph edge generator: register file, three-stage pixel pipeline and expander.
//
// Usage: each transfer on the req_ channel names one pixel by row and column.
// The rsp_ channel returns that pixel's forward edges in order (right, down,
// down-right, down-left, with border cases left out, down-left before down on
// the right border and, unless eight_connected is set, the diagonals left out),
// each followed by its reverse when directed is set. The final edge of a pixel
// carries rsp_last_edge. A pixel outside the grid, or the bottom-right pixel,
// gives no result at all. A pixel's first edge passes the input register,
// classification, multiply, node adds, expander item register and output
// register before rsp_valid shows it. Throughput: one edge per cycle while
// rsp_stall is low, and the request side takes a new pixel every cycle while
// the pipeline has room. Pixels without edges are dropped in stage 2. rsp_stall
// holds the output register and backs up through the pipeline to req_stall
// without losing or repeating anything. Reset clears all valid bits and sets
// width 2, height 2, four-connected, undirected. Configuration is written through
// the csr_ port by the user only while idle; the block does not enforce this.
module grid_graph_edge_generator_core
   import ggeg_pkg::*;
#(
   parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
   parameter int MAX_HEIGHT = DEF_MAX_HEIGHT
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    csr_psel,
   input  logic                    csr_penable,
   input  logic                    csr_pwrite,
   input  logic [CSR_ADDR_W-1:0]   csr_paddr,
   input  logic [CSR_DATA_W-1:0]   csr_pwdata,
   output logic [CSR_DATA_W-1:0]   csr_prdata,
   output logic                    csr_pready,
   input  logic                    req_valid,
   output logic                    req_stall,
   input  logic [PIXEL_W-1:0]      req_pixel_row,
   input  logic [PIXEL_W-1:0]      req_pixel_col,
   output logic                    rsp_valid,
   input  logic                    rsp_stall,
   output logic [NODE_W-1:0]       rsp_from_node,
   output logic [NODE_W-1:0]       rsp_to_node,
   output logic                    rsp_is_diagonal,
   output logic [1:0]              rsp_angle_code,
   output logic                    rsp_last_edge
);

   logic [GRID_DIM_W-1:0]   width_ff;
   logic [GRID_DIM_W-1:0]   height_ff;
   logic                    eight_ff;
   logic                    directed_ff;
   logic [GRID_DIM_W-1:0]   w_eff;
   logic [GRID_DIM_W-1:0]   h_eff;
   csr_index_type           csr_index;
   logic                    csr_write;

   logic                    s1_valid_ff;
   logic [PIXEL_W-1:0]      s1_row_ff;
   logic [PIXEL_W-1:0]      s1_col_ff;
   edge_kind_type [KIND_SLOTS-1:0] s1_kinds;
   logic [COUNT_W-1:0]      s1_count;

   logic                    s2_valid_ff;
   logic [PIXEL_W-1:0]      s2_row_ff;
   logic [PIXEL_W-1:0]      s2_col_ff;
   edge_kind_type [KIND_SLOTS-1:0] s2_kinds_ff;
   logic [COUNT_W-1:0]      s2_count_ff;

   logic                    s3_valid_ff;
   logic [NODE_W-1:0]       s3_prod_ff;
   logic [PIXEL_W-1:0]      s3_col_ff;
   edge_kind_type [KIND_SLOTS-1:0] s3_kinds_ff;
   logic [COUNT_W-1:0]      s3_count_ff;

   logic                    s1_ready;
   logic                    s2_ready;
   logic                    s3_ready;
   logic                    exp_ready;
   edge_item_type           exp_item;

   // Configuration registers.
   assign csr_index  = csr_index_type'(csr_paddr[3:2]);
   assign csr_write  = csr_psel && csr_penable && csr_pwrite && csr_pready;
   assign csr_pready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff    <= GRID_DIM_W'(2);
         height_ff   <= GRID_DIM_W'(2);
         eight_ff    <= 1'b0;
         directed_ff <= 1'b0;
      end else if (csr_write) begin
         case (csr_index)
            REG_GRID_WIDTH:      width_ff    <= csr_pwdata[GRID_DIM_W-1:0];
            REG_GRID_HEIGHT:     height_ff   <= csr_pwdata[GRID_DIM_W-1:0];
            REG_EIGHT_CONNECTED: eight_ff    <= csr_pwdata[0];
            REG_DIRECTED:        directed_ff <= csr_pwdata[0];
            default: ;
         endcase
      end
   end

   always_comb begin
      case (csr_index)
         REG_GRID_WIDTH:      csr_prdata = CSR_DATA_W'(width_ff);
         REG_GRID_HEIGHT:     csr_prdata = CSR_DATA_W'(height_ff);
         REG_EIGHT_CONNECTED: csr_prdata = CSR_DATA_W'(eight_ff);
         REG_DIRECTED:        csr_prdata = CSR_DATA_W'(directed_ff);
         default:             csr_prdata = '0;
      endcase
   end

   // Grid size limited to the largest supported grid.
   assign w_eff = (32'(width_ff) > MAX_WIDTH) ? GRID_DIM_W'(MAX_WIDTH) : width_ff;
   assign h_eff = (32'(height_ff) > MAX_HEIGHT) ? GRID_DIM_W'(MAX_HEIGHT) : height_ff;

   // Backpressure runs from the expander back to the request side.
   assign s3_ready  = !s3_valid_ff || exp_ready;
   assign s2_ready  = !s2_valid_ff || s3_ready;
   assign s1_ready  = !s1_valid_ff || s2_ready;
   assign req_stall = !s1_ready;

   // Stage 1: input register.
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (s1_ready) begin
         s1_valid_ff <= req_valid;
      end
      if (s1_ready && req_valid) begin
         s1_row_ff <= req_pixel_row;
         s1_col_ff <= req_pixel_col;
      end
   end

   // Stage 1 logic: border tests give the ordered list of edge kinds.
   always_comb begin
      logic in_grid;
      logic bottom;
      logic left_border;
      logic right_border;
      in_grid      = (w_eff >= GRID_DIM_W'(2)) && (h_eff >= GRID_DIM_W'(2)) &&
                     ({1'b0, s1_row_ff} < h_eff) && ({1'b0, s1_col_ff} < w_eff);
      bottom       = ({1'b0, s1_row_ff} == (h_eff - GRID_DIM_W'(1)));
      left_border  = (s1_col_ff == '0);
      right_border = ({1'b0, s1_col_ff} == (w_eff - GRID_DIM_W'(1)));
      s1_kinds     = {EK_DOWN_LEFT, EK_DOWN_RIGHT, EK_DOWN, EK_RIGHT};
      s1_count     = '0;
      if (!in_grid) begin
         s1_count = '0;
      end else if (bottom) begin
         s1_count = right_border ? COUNT_W'(0) : COUNT_W'(1);
      end else if (left_border) begin
         s1_count = eight_ff ? COUNT_W'(3) : COUNT_W'(2);
      end else if (right_border) begin
         if (eight_ff) begin
            s1_kinds = {EK_DOWN_LEFT, EK_DOWN_LEFT, EK_DOWN, EK_DOWN_LEFT};
            s1_count = COUNT_W'(2);
         end else begin
            s1_kinds = {EK_DOWN_LEFT, EK_DOWN_LEFT, EK_DOWN_LEFT, EK_DOWN};
            s1_count = COUNT_W'(1);
         end
      end else begin
         s1_count = eight_ff ? COUNT_W'(4) : COUNT_W'(2);
      end
   end

   // Stage 2: pixels without edges are dropped here.
   always_ff @(posedge clock) begin
      if (reset) begin
         s2_valid_ff <= 1'b0;
      end else if (s2_ready) begin
         s2_valid_ff <= s1_valid_ff && (s1_count != '0);
      end
      if (s2_ready && s1_valid_ff) begin
         s2_row_ff   <= s1_row_ff;
         s2_col_ff   <= s1_col_ff;
         s2_kinds_ff <= s1_kinds;
         s2_count_ff <= s1_count;
      end
   end

   // Stage 3: row times width is registered here.
   always_ff @(posedge clock) begin
      if (reset) begin
         s3_valid_ff <= 1'b0;
      end else if (s3_ready) begin
         s3_valid_ff <= s2_valid_ff;
      end
      if (s3_ready && s2_valid_ff) begin
         s3_prod_ff  <= NODE_W'(s2_row_ff) * NODE_W'(w_eff);
         s3_col_ff   <= s2_col_ff;
         s3_kinds_ff <= s2_kinds_ff;
         s3_count_ff <= s2_count_ff;
      end
   end

   // Stage 3 logic: start node and the node one row below it.
   always_comb begin
      exp_item.node      = s3_prod_ff + NODE_W'(s3_col_ff) + NODE_W'(1);
      exp_item.node_down = s3_prod_ff + NODE_W'(s3_col_ff) + NODE_W'(w_eff) + NODE_W'(1);
      exp_item.kinds     = s3_kinds_ff;
      exp_item.count     = s3_count_ff;
   end

   ggeg_expander u_expander (
      .clock           (clock),
      .reset           (reset),
      .directed        (directed_ff),
      .item_valid      (s3_valid_ff),
      .item            (exp_item),
      .item_ready      (exp_ready),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_from_node   (rsp_from_node),
      .rsp_to_node     (rsp_to_node),
      .rsp_is_diagonal (rsp_is_diagonal),
      .rsp_angle_code  (rsp_angle_code),
      .rsp_last_edge   (rsp_last_edge)
   );

endmodule

// ----- design/ggeg_checker.sv -----
// Port-level checker of the grid graph edge generator and its bind statement.
`include "grid_graph_edge_generator_core_assert.svh"

module ggeg_checker
   import ggeg_pkg::*;
(
   input  logic                clock,
   input  logic                reset,
   input  logic                rsp_valid,
   input  logic                rsp_stall,
   input  logic [NODE_W-1:0]   rsp_from_node,
   input  logic [NODE_W-1:0]   rsp_to_node,
   input  logic                rsp_is_diagonal,
   input  logic [1:0]          rsp_angle_code,
   input  logic                rsp_last_edge
);

   // A stalled result stays valid, with its nodes and last mark unchanged.
   `GGEG_ASSERT_NXT(a_rsp_hold, clock, reset, rsp_valid && rsp_stall, rsp_valid && $stable(rsp_from_node) && $stable(rsp_to_node) && $stable(rsp_last_edge))

   // Reset leaves no result pending.
   `GGEG_ASSERT_NXT(a_reset_empty, clock, 1'b0, reset, !rsp_valid)

   // A pixel's edges come without gaps until its last edge.
   `GGEG_ASSERT_NXT(a_run_continues, clock, reset, rsp_valid && !rsp_stall && !rsp_last_edge, rsp_valid)

   // Diagonal flag and angle code agree and the two nodes differ on every edge.
   `GGEG_ASSERT_IMP(a_diag_angle, clock, reset, rsp_valid, (rsp_is_diagonal == (rsp_angle_code == ANG_DIAG)) && (rsp_from_node != rsp_to_node))

endmodule

bind grid_graph_edge_generator_core ggeg_checker u_ggeg_checker (
   .clock           (clock),
   .reset           (reset),
   .rsp_valid       (rsp_valid),
   .rsp_stall       (rsp_stall),
   .rsp_from_node   (rsp_from_node),
   .rsp_to_node     (rsp_to_node),
   .rsp_is_diagonal (rsp_is_diagonal),
   .rsp_angle_code  (rsp_angle_code),
   .rsp_last_edge   (rsp_last_edge)
);

// ----- dv/tb_top.sv -----
// Self-checking testbench for the grid graph edge generator core.
module tb_top;
   import ggeg_pkg::*;

   localparam int CYCLE_LIMIT  = 500000;
   localparam int DRAIN_CYCLES = 12;
   localparam int RAND_PHASES  = 8;
   localparam int PHASE_PIXELS = 55;

   // One edge as it appears on the result channel.
   typedef struct packed {
      logic [NODE_W-1:0] from_node;
      logic [NODE_W-1:0] to_node;
      logic              is_diagonal;
      logic [1:0]        angle_code;
      logic              last_edge;
   } edge_rec_type;

   // Register settings of the grid.
   typedef struct packed {
      logic [GRID_DIM_W-1:0] width;
      logic [GRID_DIM_W-1:0] height;
      logic                  eight;
      logic                  directed;
   } grid_cfg_type;

   // One row of the directed stimulus: either a register setting or a pixel.
   // Pixels with known set carry their edges typed in; the others are predicted.
   typedef struct packed {
      logic                 is_cfg;
      grid_cfg_type         cfg;
      logic [PIXEL_W-1:0]   row;
      logic [PIXEL_W-1:0]   col;
      logic                 known;
      int                   n_known;
      edge_rec_type [1:0]   known_edges;
   } plan_row_type;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  csr_psel = 1'b0;
   logic                  csr_penable = 1'b0;
   logic                  csr_pwrite = 1'b0;
   logic [CSR_ADDR_W-1:0] csr_paddr = '0;
   logic [CSR_DATA_W-1:0] csr_pwdata = '0;
   logic [CSR_DATA_W-1:0] csr_prdata;
   logic                  csr_pready;
   logic                  req_valid = 1'b0;
   logic                  req_stall;
   logic [PIXEL_W-1:0]    req_pixel_row = '0;
   logic [PIXEL_W-1:0]    req_pixel_col = '0;
   logic                  rsp_valid;
   logic                  rsp_stall = 1'b0;
   logic [NODE_W-1:0]     rsp_from_node;
   logic [NODE_W-1:0]     rsp_to_node;
   logic                  rsp_is_diagonal;
   logic [1:0]            rsp_angle_code;
   logic                  rsp_last_edge;

   grid_cfg_type  grid_cfg = '{width: 13'd2, height: 13'd2, eight: 1'b0, directed: 1'b0};
   edge_rec_type  pending_edges[$];
   plan_row_type  plan[$];
   int          error_count = 0;
   int          cycle_count = 0;
   bit          squeeze_req = 1'b0;
   bit          squeeze_done = 1'b0;
   int          hold_left = 0;
   int          quiet_left = 0;

   grid_graph_edge_generator_core u_top (
      .clock           (clock),
      .reset           (reset),
      .csr_psel        (csr_psel),
      .csr_penable     (csr_penable),
      .csr_pwrite      (csr_pwrite),
      .csr_paddr       (csr_paddr),
      .csr_pwdata      (csr_pwdata),
      .csr_prdata      (csr_prdata),
      .csr_pready      (csr_pready),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_pixel_row   (req_pixel_row),
      .req_pixel_col   (req_pixel_col),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_from_node   (rsp_from_node),
      .rsp_to_node     (rsp_to_node),
      .rsp_is_diagonal (rsp_is_diagonal),
      .rsp_angle_code  (rsp_angle_code),
      .rsp_last_edge   (rsp_last_edge)
   );

   initial begin
      forever #4 clock = ~clock;
   end

   // The run is cut off if it hangs.
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("Some tests failed");
         $finish;
      end
   end

   function automatic edge_rec_type mk_edge(input longint unsigned from_n,
                                            input longint unsigned to_n,
                                            input logic diag, input logic [1:0] ang,
                                            input logic last);
      edge_rec_type e;
      e.from_node   = from_n[NODE_W-1:0];
      e.to_node     = to_n[NODE_W-1:0];
      e.is_diagonal = diag;
      e.angle_code  = ang;
      e.last_edge   = last;
      return e;
   endfunction

   // Queues one forward edge and, on a directed grid, its reverse right after it.
   task automatic push_edge(input longint unsigned a, input longint unsigned b,
                            input logic diag, input logic [1:0] ang);
      pending_edges.push_back(mk_edge(a, b, diag, ang, 1'b0));
      if (grid_cfg.directed)
         pending_edges.push_back(mk_edge(b, a, diag, ang, 1'b0));
   endtask

   // Works out the edges of one pixel under the current register settings.
   task automatic predict_edges(input logic [PIXEL_W-1:0] r, input logic [PIXEL_W-1:0] c);
      longint unsigned w;
      longint unsigned h;
      longint unsigned v;
      int              start;
      edge_rec_type    tail;
      start = pending_edges.size();
      w = (grid_cfg.width > DEF_MAX_WIDTH) ? DEF_MAX_WIDTH : grid_cfg.width;
      h = (grid_cfg.height > DEF_MAX_HEIGHT) ? DEF_MAX_HEIGHT : grid_cfg.height;
      if (w < 2 || h < 2 || r >= h || c >= w)
         return;
      v = r * w + c + 1;
      if (r == h - 1) begin
         // Bottom row: only the right edge, and none at the corner.
         if (c != w - 1)
            push_edge(v, v + 1, 1'b0, ANG_HORZ);
      end else if (c == 0) begin
         push_edge(v, v + 1, 1'b0, ANG_HORZ);
         push_edge(v, v + w, 1'b0, ANG_VERT);
         if (grid_cfg.eight)
            push_edge(v, v + w + 1, 1'b1, ANG_DIAG);
      end else if (c == w - 1) begin
         if (grid_cfg.eight)
            push_edge(v, v + w - 1, 1'b1, ANG_DIAG);
         push_edge(v, v + w, 1'b0, ANG_VERT);
      end else begin
         push_edge(v, v + 1, 1'b0, ANG_HORZ);
         push_edge(v, v + w, 1'b0, ANG_VERT);
         if (grid_cfg.eight) begin
            push_edge(v, v + w + 1, 1'b1, ANG_DIAG);
            push_edge(v, v + w - 1, 1'b1, ANG_DIAG);
         end
      end
      // The final edge of the pixel carries the last mark.
      if (pending_edges.size() > start) begin
         tail = pending_edges.pop_back();
         tail.last_edge = 1'b1;
         pending_edges.push_back(tail);
      end
   endtask

   function automatic int pick_gap(input bit burst);
      int roll;
      roll = $urandom_range(0, 99);
      if (burst || roll < 60)
         return 0;
      else if (roll < 92)
         return $urandom_range(1, 3);
      else
         return $urandom_range(8, 30);
   endfunction

   // Offers one pixel and returns at the edge where the transfer happens.
   task automatic send_pixel(input logic [PIXEL_W-1:0] r, input logic [PIXEL_W-1:0] c,
                             input bit burst);
      int gap;
      gap = pick_gap(burst);
      @(negedge clock);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_valid     <= 1'b1;
      req_pixel_row <= r;
      req_pixel_col <= c;
      do @(posedge clock); while (req_stall);
   endtask

   // Lowers valid and waits until every expected edge is in and the pipeline is empty.
   task automatic drain;
      @(negedge clock);
      req_valid <= 1'b0;
      while (pending_edges.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic csr_write(input csr_index_type idx, input logic [CSR_DATA_W-1:0] value);
      @(negedge clock);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= {idx, 2'b00};
      csr_pwdata  <= value;
      @(negedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      @(negedge clock);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      case (idx)
         REG_GRID_WIDTH:      grid_cfg.width    = value[GRID_DIM_W-1:0];
         REG_GRID_HEIGHT:     grid_cfg.height   = value[GRID_DIM_W-1:0];
         REG_EIGHT_CONNECTED: grid_cfg.eight    = value[0];
         REG_DIRECTED:        grid_cfg.directed = value[0];
         default: ;
      endcase
   endtask

   task automatic apply_cfg(input grid_cfg_type cfg);
      drain();
      csr_write(REG_GRID_WIDTH, {{(CSR_DATA_W-GRID_DIM_W){1'b0}}, cfg.width});
      csr_write(REG_GRID_HEIGHT, {{(CSR_DATA_W-GRID_DIM_W){1'b0}}, cfg.height});
      csr_write(REG_EIGHT_CONNECTED, {{(CSR_DATA_W-1){1'b0}}, cfg.eight});
      csr_write(REG_DIRECTED, {{(CSR_DATA_W-1){1'b0}}, cfg.directed});
   endtask

   task automatic plan_cfg(input int w, input int h, input bit eight, input bit dir);
      plan_row_type p;
      p = '0;
      p.is_cfg       = 1'b1;
      p.cfg.width    = GRID_DIM_W'(w);
      p.cfg.height   = GRID_DIM_W'(h);
      p.cfg.eight    = eight;
      p.cfg.directed = dir;
      plan.push_back(p);
   endtask

   task automatic plan_pixel(input int r, input int c, input bit known, input int n,
                             input edge_rec_type e0, input edge_rec_type e1);
      plan_row_type p;
      p = '0;
      p.row            = PIXEL_W'(r);
      p.col            = PIXEL_W'(c);
      p.known          = known;
      p.n_known        = n;
      p.known_edges[0] = e0;
      p.known_edges[1] = e1;
      plan.push_back(p);
   endtask

   task automatic field_check(input string name, input longint unsigned want,
                              input longint unsigned got);
      if (want !== got) begin
         $error("%s: expected %0d, got %0d", name, want, got);
         error_count++;
      end
   endtask

   // Every edge transfer is checked against the oldest expected edge.
   always @(posedge clock) begin : check_edges
      edge_rec_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (pending_edges.size() == 0) begin
            $error("unexpected edge from %0d to %0d", rsp_from_node, rsp_to_node);
            error_count++;
         end else begin
            want = pending_edges.pop_front();
            field_check("from_node", want.from_node, rsp_from_node);
            field_check("to_node", want.to_node, rsp_to_node);
            field_check("is_diagonal", want.is_diagonal, rsp_is_diagonal);
            field_check("angle_code", want.angle_code, rsp_angle_code);
            field_check("last_edge", want.last_edge, rsp_last_edge);
         end
      end
   end

   // The receiver stalls at random, with quiet stretches and one long hold-off.
   always @(negedge clock) begin : drive_stall
      int roll;
      if (squeeze_req && !squeeze_done) begin
         squeeze_done = 1'b1;
         hold_left    = 300;
      end
      if (hold_left == 0) begin
         roll = $urandom_range(0, 99);
         if (quiet_left > 0)
            quiet_left--;
         else if (roll < 4)
            hold_left = $urandom_range(10, 40);
         else if (roll < 30)
            hold_left = $urandom_range(1, 3);
         else if (roll < 33)
            quiet_left = $urandom_range(30, 80);
      end
      if (hold_left > 0) begin
         rsp_stall <= 1'b1;
         hold_left--;
      end else begin
         rsp_stall <= 1'b0;
      end
   end

   initial begin : stimulus
      edge_rec_type  none;
      grid_cfg_type  cfg;
      int          w_eff;
      int          h_eff;
      int          sel;
      int          roll;
      logic [PIXEL_W-1:0] r;
      logic [PIXEL_W-1:0] c;
      bit          burst;

      none = '0;
      // Settings right after reset: 2 by 2, four-connected, undirected.
      plan_pixel(0, 0, 1, 2, mk_edge(1, 2, 1'b0, ANG_HORZ, 1'b0),
                 mk_edge(1, 3, 1'b0, ANG_VERT, 1'b1));
      plan_pixel(0, 1, 1, 1, mk_edge(2, 4, 1'b0, ANG_VERT, 1'b1), none);
      plan_pixel(1, 0, 1, 1, mk_edge(3, 4, 1'b0, ANG_HORZ, 1'b1), none);
      plan_pixel(1, 1, 1, 0, none, none);
      plan_pixel(2, 0, 1, 0, none, none);
      plan_pixel(4095, 4095, 1, 0, none, none);
      // Small grid, eight-connected and directed: every border case.
      plan_cfg(5, 4, 1, 1);
      plan_pixel(0, 0, 0, 0, none, none);
      plan_pixel(1, 2, 0, 0, none, none);
      plan_pixel(2, 4, 0, 0, none, none);
      plan_pixel(3, 2, 0, 0, none, none);
      plan_pixel(3, 4, 1, 0, none, none);
      plan_pixel(0, 5, 1, 0, none, none);
      // Largest grid.
      plan_cfg(4096, 4096, 1, 0);
      plan_pixel(0, 0, 0, 0, none, none);
      plan_pixel(4094, 4095, 0, 0, none, none);
      plan_pixel(4095, 4094, 0, 0, none, none);
      plan_pixel(4095, 4095, 1, 0, none, none);
      plan_pixel(2047, 2048, 0, 0, none, none);
      // Width beyond the maximum is clipped to it.
      plan_cfg(8191, 3, 0, 1);
      plan_pixel(0, 4095, 0, 0, none, none);
      plan_pixel(2, 100, 0, 0, none, none);
      // Degenerate grids give nothing.
      plan_cfg(1, 5, 1, 1);
      plan_pixel(0, 0, 1, 0, none, none);
      plan_cfg(0, 0, 0, 0);
      plan_pixel(0, 0, 1, 0, none, none);

      repeat (5) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Directed part.
      foreach (plan[i]) begin
         if (plan[i].is_cfg) begin
            apply_cfg(plan[i].cfg);
         end else begin
            send_pixel(plan[i].row, plan[i].col, 1'b0);
            if (plan[i].known) begin
               for (int k = 0; k < plan[i].n_known; k++)
                  pending_edges.push_back(plan[i].known_edges[k]);
            end else begin
               predict_edges(plan[i].row, plan[i].col);
            end
         end
      end

      // Random part: one register setting per phase, mostly small grids.
      for (int ph = 0; ph < RAND_PHASES; ph++) begin
         sel = (ph < 2) ? 5 : $urandom_range(0, 9);
         if (sel == 0) begin
            cfg.width  = GRID_DIM_W'($urandom_range(0, 1));
            cfg.height = GRID_DIM_W'($urandom_range(0, 8));
         end else if (sel == 1) begin
            cfg.width  = GRID_DIM_W'($urandom_range(2, 8191));
            cfg.height = GRID_DIM_W'($urandom_range(2, 8191));
         end else begin
            cfg.width  = GRID_DIM_W'($urandom_range(2, 9));
            cfg.height = GRID_DIM_W'($urandom_range(2, 9));
         end
         cfg.eight    = 1'($urandom_range(0, 1));
         cfg.directed = (ph == 1) ? 1'b1 : 1'(($urandom_range(0, 1)));
         apply_cfg(cfg);
         w_eff = (cfg.width > DEF_MAX_WIDTH) ? DEF_MAX_WIDTH : cfg.width;
         h_eff = (cfg.height > DEF_MAX_HEIGHT) ? DEF_MAX_HEIGHT : cfg.height;
         // The second phase runs without gaps while the receiver holds off.
         burst = (ph == 1) || (ph % 3 == 2);
         if (ph == 1)
            squeeze_req = 1'b1;
         for (int n = 0; n < PHASE_PIXELS; n++) begin
            roll = $urandom_range(0, 99);
            if (roll < 15 || w_eff < 2 || h_eff < 2) begin
               r = PIXEL_W'($urandom_range(0, 4095));
               c = PIXEL_W'($urandom_range(0, 4095));
            end else begin
               r = PIXEL_W'($urandom_range(0, h_eff - 1));
               c = PIXEL_W'($urandom_range(0, w_eff - 1));
               // Bias part of the pixels onto the borders.
               if (roll < 25)
                  r = PIXEL_W'(h_eff - 1);
               else if (roll < 32)
                  c = '0;
               else if (roll < 39)
                  c = PIXEL_W'(w_eff - 1);
            end
            send_pixel(r, c, burst);
            predict_edges(r, c);
         end
      end

      drain();
      if (error_count == 0) begin
         $display("All tests passed");
      end else begin
         $display("Some tests failed");
      end
      $finish;
   end

endmodule
